>>> rtl/bms_chs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_chs_pkg
// Types, codes and tables shared by the charging handshake sequencer.
// ----------------------------------------------------------------------------
package bms_chs_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CCS_CNT_W   = 7;
    localparam int MASK_W      = 10;

    typedef logic [TIMER_WIDTH-1:0] t_timer;
    typedef logic [CFG_W-1:0]       t_cfg;
    typedef logic [CCS_CNT_W-1:0]   t_ccs_cnt;
    typedef logic [MASK_W-1:0]      t_mask;

    localparam t_timer TIMER_MAX = '1;

    typedef enum logic [3:0] {
        PH_INIT   = 4'd0,
        PH_CONN   = 4'd1,
        PH_BHM    = 4'd2,
        PH_BRM    = 4'd3,
        PH_BCP    = 4'd4,
        PH_BRO00  = 4'd6,
        PH_BROAA  = 4'd7,
        PH_CRO    = 4'd8,
        PH_BCLBCS = 4'd9,
        PH_BSM    = 4'd10,
        PH_BST    = 4'd11,
        PH_BSD    = 4'd12,
        PH_EXIT   = 4'd13
    } t_phase;

    typedef enum logic [1:0] {
        CAUSE_RUN     = 2'd0,
        CAUSE_TIMEOUT = 2'd1,
        CAUSE_ABORT   = 2'd2,
        CAUSE_NORMAL  = 2'd3
    } t_cause;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_FRAME = 3'd2,
        CMD_PREP  = 3'd3,
        CMD_ABORT = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        FK_CHM   = 3'd0,
        FK_CRM   = 3'd1,
        FK_CML   = 3'd2,
        FK_CRO   = 3'd3,
        FK_CCS   = 3'd4,
        FK_CST   = 3'd5,
        FK_CSD   = 3'd6,
        FK_OTHER = 3'd7
    } t_frame_kind;

    localparam logic [CFG_IDX_W-1:0] REG_CRM_ZERO_TO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRO_READY_TO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CCS_TO       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CSD_TO       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CCS_STOP     = 3'd5;

    localparam logic [7:0] BYTE_00 = 8'h00;
    localparam logic [7:0] BYTE_AA = 8'hAA;

    // Reset values of the configuration registers
    localparam t_cfg     RST_CRM_ZERO_TO  = 16'd30;
    localparam t_cfg     RST_SHORT_TO     = 16'd5;
    localparam t_cfg     RST_CRO_READY_TO = 16'd60;
    localparam t_cfg     RST_CCS_TO       = 16'd5;
    localparam t_cfg     RST_CSD_TO       = 16'd10;
    localparam t_ccs_cnt RST_CCS_STOP     = 7'd100;

    // Periodic frames: bit0 BHM .. bit9 BSD
    function automatic t_mask mask_of_phase(input t_phase ph);
        t_mask m;
        case (ph)
            PH_BHM:    m = 10'h001;
            PH_BRM:    m = 10'h002;
            PH_BCP:    m = 10'h004;
            PH_BRO00:  m = 10'h008;
            PH_BROAA:  m = 10'h010;
            PH_CRO:    m = 10'h010;
            PH_BCLBCS: m = 10'h060;
            PH_BSM:    m = 10'h0E0;
            PH_BST:    m = 10'h1E0;
            PH_BSD:    m = 10'h2E0;
            default:   m = '0;
        endcase
        return m;
    endfunction

    // Saturate a register value into the timer width
    function automatic t_timer timer_load(input t_cfg v);
        logic [CFG_W+TIMER_WIDTH-1:0] wide;
        wide = (CFG_W+TIMER_WIDTH)'(v);
        if (wide > (CFG_W+TIMER_WIDTH)'(TIMER_MAX)) begin
            return TIMER_MAX;
        end
        return wide[TIMER_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/bms_charge_handshake_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_charge_handshake_sequencer
// Battery-side charging session sequencer with reply timeouts and CCS count.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | i_in_valid/o_in_ready, command/kind/byte  | in
//  out     | o_out_valid/i_out_ready, state/mask/cause | out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
//  One transfer in gives one result, held in the result register or the skid.
//  Session state updates in the same edge that takes the item; a two-entry
//  output buffer (result register plus skid) lets one more item in while a
//  result waits, so throughput is one item per cycle when the sink keeps up.
//  i_rst_n is synchronous, active low: session returns to init, registers to
//  their defaults, output buffer empties.
// ----------------------------------------------------------------------------
module bms_charge_handshake_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [2:0]                         i_command,
    input  logic [2:0]                         i_frame_kind,
    input  logic [7:0]                         i_frame_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [3:0]                         o_session_state,
    output logic [bms_chs_pkg::MASK_W-1:0]     o_send_mask,
    output logic [1:0]                         o_exit_cause,
    input  logic                               i_cfg_we,
    input  logic [bms_chs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bms_chs_pkg::CFG_W-1:0]      i_cfg_data
);
    import bms_chs_pkg::*;

    typedef struct packed {
        t_phase phase;
        t_mask  mask;
        t_cause cause;
    } t_result;

    // Configuration
    t_cfg     r_crm_zero_to, r_short_to, r_cro_ready_to, r_ccs_to, r_csd_to;
    t_ccs_cnt r_ccs_stop;

    // Session state
    t_phase   r_phase, n_phase;
    t_timer   r_tmr1, n_tmr1, r_tmr2, n_tmr2;
    logic     r_tmr1_on, n_tmr1_on, r_tmr2_on, n_tmr2_on;
    logic     r_stop_seen, n_stop_seen;
    t_ccs_cnt r_ccs_cnt, n_ccs_cnt;
    t_cause   r_cause, n_cause;

    // Output buffer
    t_result  r_out, r_skid, new_res;
    logic     r_out_valid, r_skid_valid;
    logic     in_fire, out_fire;
    logic     tmr1_exp, tmr2_exp;
    t_ccs_cnt ccs_inc;

    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crm_zero_to  <= RST_CRM_ZERO_TO;
            r_short_to     <= RST_SHORT_TO;
            r_cro_ready_to <= RST_CRO_READY_TO;
            r_ccs_to       <= RST_CCS_TO;
            r_csd_to       <= RST_CSD_TO;
            r_ccs_stop     <= RST_CCS_STOP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CRM_ZERO_TO:  r_crm_zero_to  <= i_cfg_data;
                REG_SHORT_TO:     r_short_to     <= i_cfg_data;
                REG_CRO_READY_TO: r_cro_ready_to <= i_cfg_data;
                REG_CCS_TO:       r_ccs_to       <= i_cfg_data;
                REG_CSD_TO:       r_csd_to       <= i_cfg_data;
                REG_CCS_STOP:     r_ccs_stop     <= i_cfg_data[CCS_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INIT;
            r_tmr1      <= '0;
            r_tmr2      <= '0;
            r_tmr1_on   <= 1'b0;
            r_tmr2_on   <= 1'b0;
            r_stop_seen <= 1'b0;
            r_ccs_cnt   <= '0;
            r_cause     <= CAUSE_RUN;
        end else begin
            r_phase     <= n_phase;
            r_tmr1      <= n_tmr1;
            r_tmr2      <= n_tmr2;
            r_tmr1_on   <= n_tmr1_on;
            r_tmr2_on   <= n_tmr2_on;
            r_stop_seen <= n_stop_seen;
            r_ccs_cnt   <= n_ccs_cnt;
            r_cause     <= n_cause;
        end
    end

    assign tmr1_exp = r_tmr1_on && (r_tmr1 <= t_timer'(1));
    assign tmr2_exp = r_tmr2_on && (r_tmr2 <= t_timer'(1));
    assign ccs_inc  = r_ccs_cnt + t_ccs_cnt'(1);

    always_comb begin
        n_phase     = r_phase;
        n_tmr1      = r_tmr1;
        n_tmr2      = r_tmr2;
        n_tmr1_on   = r_tmr1_on;
        n_tmr2_on   = r_tmr2_on;
        n_stop_seen = r_stop_seen;
        n_ccs_cnt   = r_ccs_cnt;
        n_cause     = r_cause;
        if (in_fire && r_phase != PH_EXIT) begin
            case (i_command)
                CMD_TICK: begin
                    if (r_tmr1_on) begin
                        n_tmr1    = tmr1_exp ? '0 : r_tmr1 - t_timer'(1);
                        n_tmr1_on = !tmr1_exp;
                    end
                    if (r_tmr2_on) begin
                        n_tmr2    = tmr2_exp ? '0 : r_tmr2 - t_timer'(1);
                        n_tmr2_on = !tmr2_exp;
                    end
                    if (tmr1_exp || tmr2_exp) begin
                        n_phase   = PH_EXIT;
                        n_cause   = CAUSE_TIMEOUT;
                        n_tmr1_on = 1'b0;
                        n_tmr2_on = 1'b0;
                    end
                end
                CMD_START: begin
                    if (r_phase == PH_INIT) begin
                        n_phase = PH_CONN;
                    end
                end
                CMD_FRAME: begin
                    case (i_frame_kind)
                        FK_CHM: begin
                            if (r_phase == PH_CONN) begin
                                n_phase   = PH_BHM;
                                n_tmr1    = timer_load(r_crm_zero_to);
                                n_tmr1_on = 1'b1;
                            end
                        end
                        FK_CRM: begin
                            if (r_phase == PH_BHM && i_frame_byte == BYTE_00) begin
                                n_phase   = PH_BRM;
                                n_tmr1    = timer_load(r_short_to);
                                n_tmr1_on = 1'b1;
                            end else if (r_phase == PH_BRM && i_frame_byte == BYTE_AA) begin
                                n_phase   = PH_BCP;
                                n_tmr1    = timer_load(r_short_to);
                                n_tmr1_on = 1'b1;
                            end
                        end
                        FK_CML: begin
                            if (r_phase == PH_BCP) begin
                                n_phase   = PH_BRO00;
                                n_tmr1_on = 1'b0;
                            end
                        end
                        FK_CRO: begin
                            // any CRO byte moves to cro; only CRO AA starts charging
                            if (r_phase == PH_BROAA) begin
                                n_phase   = PH_CRO;
                                n_tmr1_on = 1'b0;
                            end else if (r_phase == PH_CRO && i_frame_byte == BYTE_AA) begin
                                n_phase   = PH_BCLBCS;
                                n_tmr2_on = 1'b0;
                                n_tmr1    = timer_load(r_ccs_to);
                                n_tmr1_on = 1'b1;
                            end
                        end
                        FK_CCS: begin
                            if (r_phase == PH_BCLBCS) begin
                                n_phase   = PH_BSM;
                                n_tmr1_on = 1'b0;
                            end else if (r_phase == PH_BSM) begin
                                n_ccs_cnt = ccs_inc;
                                if (ccs_inc == r_ccs_stop) begin
                                    n_phase   = PH_BST;
                                    n_tmr1    = timer_load(r_short_to);
                                    n_tmr1_on = 1'b1;
                                    n_tmr2    = timer_load(r_csd_to);
                                    n_tmr2_on = 1'b1;
                                end
                            end
                        end
                        FK_CST: begin
                            // early CST skips the CST wait; late CST moves to bsd
                            if (r_phase == PH_BSM) begin
                                n_stop_seen = 1'b1;
                                n_phase     = PH_BST;
                                n_tmr1_on   = 1'b0;
                                n_tmr2      = timer_load(r_csd_to);
                                n_tmr2_on   = 1'b1;
                            end else if (r_phase == PH_BST && !r_stop_seen) begin
                                n_stop_seen = 1'b1;
                                n_tmr1_on   = 1'b0;
                                n_phase     = PH_BSD;
                            end
                        end
                        FK_CSD: begin
                            if (r_phase == PH_BSD || (r_phase == PH_BST && r_stop_seen)) begin
                                n_phase   = PH_EXIT;
                                n_cause   = CAUSE_NORMAL;
                                n_tmr1_on = 1'b0;
                                n_tmr2_on = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_PREP: begin
                    if (r_phase == PH_BRO00) begin
                        n_phase   = PH_BROAA;
                        n_tmr1    = timer_load(r_short_to);
                        n_tmr1_on = 1'b1;
                        n_tmr2    = timer_load(r_cro_ready_to);
                        n_tmr2_on = 1'b1;
                    end
                end
                CMD_ABORT: begin
                    n_phase   = PH_EXIT;
                    n_cause   = CAUSE_ABORT;
                    n_tmr1_on = 1'b0;
                    n_tmr2_on = 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign new_res = '{phase: n_phase, mask: mask_of_phase(n_phase), cause: n_cause};

    // Result register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_fire && (!r_out_valid || out_fire)) begin
                r_out_valid <= 1'b1;
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (!r_out_valid || out_fire)) begin
            r_out <= new_res;
        end else if (in_fire) begin
            r_skid <= new_res;
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_session_state = r_out.phase;
    assign o_send_mask     = r_out.mask;
    assign o_exit_cause    = r_out.cause;

endmodule

>>> rtl/bms_chs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_chs_checker
// Port-level checks on the charging handshake sequencer, bound to the top.
// ----------------------------------------------------------------------------
module bms_chs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [3:0]                     o_session_state,
    input logic [bms_chs_pkg::MASK_W-1:0] o_send_mask,
    input logic [1:0]                     o_exit_cause
);
    import bms_chs_pkg::*;

    // A pending result holds until the sink takes it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_session_state)
            && $stable(o_exit_cause))
        else $error("result dropped or changed while stalled");

    // The input side only backs up when a result is waiting
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty output");

    // A nonzero exit cause is shown exactly in the exit state
    a_cause_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_exit_cause != CAUSE_RUN) == (o_session_state == PH_EXIT)))
        else $error("exit cause and state disagree");

    // No periodic frame outside an active session
    a_mask_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_session_state == PH_INIT || o_session_state == PH_CONN
            || o_session_state == PH_EXIT) |-> o_send_mask == '0)
        else $error("send mask active outside a session");

endmodule

bind bms_charge_handshake_sequencer bms_chs_checker u_bms_chs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_session_state (o_session_state),
    .o_send_mask     (o_send_mask),
    .o_exit_cause    (o_exit_cause)
);

>>> tb/bms_charge_handshake_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_charge_handshake_sequencer_test
// Drives one charging session from init to exit, through every phase up to bsm. Filler
// transfers that leave the phase alone are mixed in between steps, and the
// charging phase carries most of the traffic while the stop count is
// rewritten. The session ends by CSD, by timer expiry or by abort, and the
// seed picks which. Every status transfer is checked field by field against
// a transaction-level model of the session.
// ----------------------------------------------------------------------------
module bms_charge_handshake_sequencer_test;
    import bms_chs_pkg::*;

    localparam int ITEM_TARGET  = 1050;
    localparam int TAIL_ITEMS   = 60;
    localparam int QUIET_LIMIT  = 600;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {END_NORMAL, END_TIMEOUT, END_ABORT} t_wrapup;

    typedef struct {
        t_phase   ph;
        t_timer   t1;
        bit       on1;
        t_timer   t2;
        bit       on2;
        bit       stop_seen;
        t_ccs_cnt ccs;
        t_cause   cause;
    } t_sess;

    typedef struct {
        t_phase ph;
        t_mask  mask;
        t_cause cause;
    } t_status;

    class session_scoreboard;
        t_cfg     crm0_to;
        t_cfg     short_to;
        t_cfg     cro_rdy_to;
        t_cfg     ccs_to;
        t_cfg     csd_to;
        t_ccs_cnt ccs_stop;
        t_sess    sess;
        t_status  due_status[$];
        int       errors;

        function new();
            crm0_to         = RST_CRM_ZERO_TO;
            short_to        = RST_SHORT_TO;
            cro_rdy_to      = RST_CRO_READY_TO;
            ccs_to          = RST_CCS_TO;
            csd_to          = RST_CSD_TO;
            ccs_stop        = RST_CCS_STOP;
            sess.ph         = PH_INIT;
            sess.t1         = '0;
            sess.on1        = 1'b0;
            sess.t2         = '0;
            sess.on2        = 1'b0;
            sess.stop_seen  = 1'b0;
            sess.ccs        = '0;
            sess.cause      = CAUSE_RUN;
            errors          = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_cfg data);
            case (idx)
                REG_CRM_ZERO_TO:  crm0_to    = data;
                REG_SHORT_TO:     short_to   = data;
                REG_CRO_READY_TO: cro_rdy_to = data;
                REG_CCS_TO:       ccs_to     = data;
                REG_CSD_TO:       csd_to     = data;
                REG_CCS_STOP:     ccs_stop   = data[CCS_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_mask frames_for(t_phase ph);
            case (ph)
                PH_BHM:    return 10'h001;
                PH_BRM:    return 10'h002;
                PH_BCP:    return 10'h004;
                PH_BRO00:  return 10'h008;
                PH_BROAA:  return 10'h010;
                PH_CRO:    return 10'h010;
                PH_BCLBCS: return 10'h060;
                PH_BSM:    return 10'h0E0;
                PH_BST:    return 10'h1E0;
                PH_BSD:    return 10'h2E0;
                default:   return 10'h000;
            endcase
        endfunction

        function t_sess end_session(t_sess s, t_cause why);
            s.ph    = PH_EXIT;
            s.cause = why;
            s.on1   = 1'b0;
            s.on2   = 1'b0;
            return s;
        endfunction

        // Timer and register widths match, so a load never needs a clamp
        function t_sess frame_after(t_sess s, logic [2:0] kind, logic [7:0] fb);
            case (kind)
                FK_CHM: begin
                    if (s.ph == PH_CONN) begin
                        s.ph = PH_BHM; s.t1 = crm0_to; s.on1 = 1'b1;
                    end
                end
                FK_CRM: begin
                    if (s.ph == PH_BHM && fb == BYTE_00) begin
                        s.ph = PH_BRM; s.t1 = short_to; s.on1 = 1'b1;
                    end else if (s.ph == PH_BRM && fb == BYTE_AA) begin
                        s.ph = PH_BCP; s.t1 = short_to; s.on1 = 1'b1;
                    end
                end
                FK_CML: begin
                    if (s.ph == PH_BCP) begin
                        s.ph = PH_BRO00; s.on1 = 1'b0;
                    end
                end
                FK_CRO: begin
                    if (s.ph == PH_BROAA) begin
                        s.ph = PH_CRO; s.on1 = 1'b0;
                    end else if (s.ph == PH_CRO && fb == BYTE_AA) begin
                        s.ph  = PH_BCLBCS;
                        s.on2 = 1'b0;
                        s.t1  = ccs_to;
                        s.on1 = 1'b1;
                    end
                end
                FK_CCS: begin
                    if (s.ph == PH_BCLBCS) begin
                        s.ph = PH_BSM; s.on1 = 1'b0;
                    end else if (s.ph == PH_BSM) begin
                        // 7-bit counter, wraps
                        s.ccs = s.ccs + t_ccs_cnt'(1);
                        if (s.ccs == ccs_stop) begin
                            s.ph  = PH_BST;
                            s.t1  = short_to;
                            s.on1 = 1'b1;
                            s.t2  = csd_to;
                            s.on2 = 1'b1;
                        end
                    end
                end
                FK_CST: begin
                    if (s.ph == PH_BSM) begin
                        // early stop from the charger: no CST wait in bst
                        s.stop_seen = 1'b1;
                        s.ph        = PH_BST;
                        s.on1       = 1'b0;
                        s.t2        = csd_to;
                        s.on2       = 1'b1;
                    end else if (s.ph == PH_BST && !s.stop_seen) begin
                        s.stop_seen = 1'b1;
                        s.on1       = 1'b0;
                        s.ph        = PH_BSD;
                    end
                end
                FK_CSD: begin
                    if (s.ph == PH_BSD || (s.ph == PH_BST && s.stop_seen))
                        s = end_session(s, CAUSE_NORMAL);
                end
                default: ;
            endcase
            return s;
        endfunction

        function t_sess session_after(t_sess s, logic [2:0] cmd, logic [2:0] kind,
                                      logic [7:0] fb);
            bit e1;
            bit e2;
            e1 = 1'b0;
            e2 = 1'b0;
            if (s.ph == PH_EXIT)
                return s;
            case (cmd)
                CMD_TICK: begin
                    if (s.on1) begin
                        if (s.t1 <= t_timer'(1)) begin
                            s.t1 = '0; s.on1 = 1'b0; e1 = 1'b1;
                        end else begin
                            s.t1 = s.t1 - t_timer'(1);
                        end
                    end
                    if (s.on2) begin
                        if (s.t2 <= t_timer'(1)) begin
                            s.t2 = '0; s.on2 = 1'b0; e2 = 1'b1;
                        end else begin
                            s.t2 = s.t2 - t_timer'(1);
                        end
                    end
                    if (e1 || e2)
                        s = end_session(s, CAUSE_TIMEOUT);
                end
                CMD_START: begin
                    if (s.ph == PH_INIT)
                        s.ph = PH_CONN;
                end
                CMD_FRAME: s = frame_after(s, kind, fb);
                CMD_PREP: begin
                    if (s.ph == PH_BRO00) begin
                        s.ph  = PH_BROAA;
                        s.t1  = short_to;
                        s.on1 = 1'b1;
                        s.t2  = cro_rdy_to;
                        s.on2 = 1'b1;
                    end
                end
                CMD_ABORT: s = end_session(s, CAUSE_ABORT);
                default: ;
            endcase
            return s;
        endfunction

        function void note_transfer(logic [2:0] cmd, logic [2:0] kind, logic [7:0] fb);
            t_status st;
            sess     = session_after(sess, cmd, kind, fb);
            st.ph    = sess.ph;
            st.mask  = frames_for(sess.ph);
            st.cause = sess.cause;
            due_status.push_back(st);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] ERROR %s", $time, msg);
        endtask

        task check_status(logic [3:0] ph, t_mask m, logic [1:0] c);
            t_status want;
            if (due_status.size() == 0) begin
                report($sformatf("status with no transfer pending: state=%0d mask=%h cause=%0d",
                                 ph, m, c));
                return;
            end
            want = due_status.pop_front();
            if (ph !== want.ph)
                report($sformatf("session_state %0d, predicted %0d", ph, want.ph));
            if (m !== want.mask)
                report($sformatf("send_mask %h, predicted %h", m, want.mask));
            if (c !== want.cause)
                report($sformatf("exit_cause %0d, predicted %0d", c, want.cause));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [2:0]           command   = '0;
    logic [2:0]           kind      = '0;
    logic [7:0]           fbyte     = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    t_cfg                 cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic [3:0]           sess_state;
    t_mask                send_mask;
    logic [1:0]           exit_cause;

    session_scoreboard sb;
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    int sent        = 0;
    int quiet       = 0;

    bms_charge_handshake_sequencer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (command),
        .i_frame_kind    (kind),
        .i_frame_byte    (fbyte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_session_state (sess_state),
        .o_send_mask     (send_mask),
        .o_exit_cause    (exit_cause),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 3))
            0:       return BYTE_00;
            1:       return BYTE_AA;
            2:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_cfg timeout_value();
        case ($urandom_range(0, 3))
            0:       return t_cfg'(1);
            1:       return t_cfg'(2);
            2:       return TIMER_MAX;
            default: return t_cfg'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic t_cfg stop_value();
        case ($urandom_range(0, 2))
            0:       return t_cfg'(1);
            1:       return t_cfg'(127);
            default: return t_cfg'($urandom_range(1, 127));
        endcase
    endfunction

    // A filler transfer leaves the session phase where it is
    function automatic bit is_filler(logic [2:0] cmd, logic [2:0] kd, logic [7:0] fb);
        t_sess nxt;
        nxt = sb.session_after(sb.sess, cmd, kd, fb);
        return nxt.ph == sb.sess.ph;
    endfunction

    task automatic send_item(input logic [2:0] cmd, input logic [2:0] kd,
                             input logic [7:0] fb);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        kind     <= kd;
        fbyte    <= fb;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_transfer(cmd, kd, fb);
        sent++;
    endtask

    task automatic send_filler(input int n);
        logic [2:0] cmd;
        logic [2:0] kd;
        logic [7:0] fb;
        repeat (n) begin
            do begin
                kd = 3'($urandom_range(0, 7));
                fb = any_byte();
                if ($urandom_range(0, 1) == 0) begin
                    cmd = CMD_FRAME;
                    // load the CCS counter while charging
                    if (sb.sess.ph == PH_BSM)
                        kd = FK_CCS;
                end else begin
                    cmd = 3'($urandom_range(0, 7));
                end
            end while (!is_filler(cmd, kd, fb));
            send_item(cmd, kd, fb);
        end
    endtask

    // Well-formed transfer that moves the session on from its phase; bsm and exit get a tick that stays put
    task automatic send_forward();
        case (sb.sess.ph)
            PH_INIT:   send_item(CMD_START, 3'($urandom_range(0, 7)), any_byte());
            PH_CONN:   send_item(CMD_FRAME, FK_CHM, any_byte());
            PH_BHM:    send_item(CMD_FRAME, FK_CRM, BYTE_00);
            PH_BRM:    send_item(CMD_FRAME, FK_CRM, BYTE_AA);
            PH_BCP:    send_item(CMD_FRAME, FK_CML, any_byte());
            PH_BRO00:  send_item(CMD_PREP, 3'($urandom_range(0, 7)), any_byte());
            PH_BROAA:  send_item(CMD_FRAME, FK_CRO, any_byte());
            PH_CRO:    send_item(CMD_FRAME, FK_CRO, BYTE_AA);
            PH_BCLBCS: send_item(CMD_FRAME, FK_CCS, any_byte());
            PH_BST:    send_item(CMD_FRAME, sb.sess.stop_seen ? FK_CSD : FK_CST, any_byte());
            PH_BSD:    send_item(CMD_FRAME, FK_CSD, any_byte());
            default:   send_item(CMD_TICK, 3'($urandom_range(0, 7)), any_byte());
        endcase
    endtask

    // Drop valid and wait until every status has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.due_status.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_cfg data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_random_reg();
        logic [CFG_IDX_W-1:0] idx;
        idx = 3'($urandom_range(0, 7));
        if (idx == REG_CCS_STOP)
            write_reg(idx, stop_value());
        else if (idx == REG_SPARE_LO || idx == REG_SPARE_HI)
            write_reg(idx, t_cfg'($urandom));
        else
            write_reg(idx, timeout_value());
    endtask

    initial begin
        t_wrapup  ending;
        bit       by_count;
        int       kth;
        t_ccs_cnt stop;
        t_cfg     short_v;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_CRM_ZERO_TO, timeout_value());
        write_reg(REG_SHORT_TO, timeout_value());
        write_reg(REG_CRO_READY_TO, timeout_value());
        write_reg(REG_CCS_TO, timeout_value());
        write_reg(REG_CSD_TO, timeout_value());
        write_reg(REG_CCS_STOP, stop_value());
        write_reg(REG_SPARE_LO, t_cfg'($urandom));
        write_reg(REG_SPARE_HI, TIMER_MAX);

        // Directed: everything ignored in init, then the handshake opening
        send_item(CMD_TICK, FK_OTHER, 8'hFF);
        send_item(CMD_PREP, FK_CRO, BYTE_AA);
        for (int c = CMD_ABORT + 1; c < 8; c++)
            send_item(3'(c), FK_CHM, 8'hFF);
        for (int k = FK_CHM; k <= FK_OTHER; k++)
            send_item(CMD_FRAME, 3'(k), (k % 2 != 0) ? BYTE_AA : BYTE_00);
        send_item(CMD_START, FK_OTHER, BYTE_00);
        send_item(CMD_START, FK_CHM, 8'hFF);
        send_item(CMD_FRAME, FK_CRM, BYTE_00);
        send_item(CMD_FRAME, FK_CHM, 8'h55);
        if (is_filler(CMD_TICK, FK_OTHER, BYTE_00))
            send_item(CMD_TICK, FK_OTHER, BYTE_00);
        send_item(CMD_FRAME, FK_CRM, BYTE_AA);
        send_item(CMD_FRAME, FK_CRM, 8'hFF);
        send_item(CMD_FRAME, FK_CRM, BYTE_00);

        // Walk up to charging with filler mixed in between steps
        while (sb.sess.ph != PH_BSM) begin
            if ($urandom_range(0, 2) == 0) begin
                settle();
                write_random_reg();
            end
            send_filler($urandom_range(0, 8));
            send_forward();
        end

        // Bulk of the run: charging, stop count moved between bursts
        while (sent < ITEM_TARGET - TAIL_ITEMS) begin
            settle();
            src_idle_on = $urandom_range(0, 3) != 0;
            snk_idle_on = $urandom_range(0, 3) != 0;
            write_reg(REG_CCS_STOP, stop_value());
            if ($urandom_range(0, 1) == 0)
                write_random_reg();
            send_filler($urandom_range(20, 80));
        end

        settle();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        ending   = t_wrapup'($urandom_range(0, 2));
        by_count = $urandom_range(0, 1) != 0;
        short_v  = t_cfg'($urandom_range(1, 12));
        write_reg(REG_SHORT_TO, short_v);
        // equal values make both timers run out on the same tick
        write_reg(REG_CSD_TO, ($urandom_range(0, 1) == 0) ? short_v
                                                          : t_cfg'($urandom_range(1, 12)));
        if (by_count) begin
            kth  = $urandom_range(1, 6);
            stop = sb.sess.ccs + t_ccs_cnt'(kth);
            if (stop == '0)
                stop = t_ccs_cnt'(1);
            write_reg(REG_CCS_STOP, t_cfg'(stop));
        end

        while (sb.sess.ph == PH_BSM) begin
            send_filler($urandom_range(0, 4));
            send_item(CMD_FRAME, by_count ? FK_CCS : FK_CST, any_byte());
        end

        while (sb.sess.ph != PH_EXIT) begin
            send_filler($urandom_range(0, 3));
            case (ending)
                END_NORMAL:  send_forward();
                END_TIMEOUT: send_item(CMD_TICK, 3'($urandom_range(0, 7)), any_byte());
                default:     send_item(CMD_ABORT, 3'($urandom_range(0, 7)), any_byte());
            endcase
        end

        // Exit holds until reset, whatever arrives
        send_filler(8);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sink: random stall bursts between open stretches
    initial begin
        do @(posedge clk); while (!rst_n);
        forever begin
            if (snk_idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_status(sess_state, send_mask, exit_cause);
    end

    // Watchdog: end the run when no transfer moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule

>>> bms_charge_handshake_sequencer.f
rtl/bms_chs_pkg.sv
rtl/bms_charge_handshake_sequencer.sv
rtl/bms_chs_checker.sv
tb/bms_charge_handshake_sequencer_test.sv
